>>> rtl/assert_macros.svh
// Assertion helpers for the level tracker.
// All checks sample on the rising edge of clk and are off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked every cycle outside reset.
`define ASL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property that must hold whenever the output channel shows a request.
`define ASL_ASSERT_OUT(label, expr, msg) \
    `ASL_ASSERT(label, out_valid |-> (expr), msg)

`endif

>>> rtl/asl_pkg.sv
// ----------------------------------------------------------------------------
// asl_pkg
// Shared widths, reset values, register indexes and control structs of the
// audio scope level tracker.
// ----------------------------------------------------------------------------
package asl_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SQ_W     = 32;
    localparam int SUM_W    = 56;
    localparam int CNT_W    = 24;
    localparam int ROOT_W   = SUM_W / 2;
    localparam int LEVEL_W  = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    localparam int DEF_RING_COLUMNS = 400;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPC   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CPB   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIV   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BPW   = 3'd4;

    // register reset values
    localparam logic [7:0]  RST_SPC   = 8'd40;
    localparam logic [6:0]  RST_CPB   = 7'd8;
    localparam logic [15:0] RST_FLOOR = 16'd1200;
    localparam logic [7:0]  RST_DIV   = 8'd24;
    localparam logic [9:0]  RST_BPW   = 10'd50;

    localparam logic [6:0]  MAX_CPB   = 7'd64;
    localparam logic [15:0] MAX_FLOOR = 16'd32768;

    localparam logic signed [SAMPLE_W-1:0] MIN_INIT = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] MAX_INIT = 16'sh8000;

    typedef struct packed {
        logic load;
        logic accumulate;
        logic step_sample;
        logic div_start;
        logic div_decay;
        logic sqrt_start;
        logic store_rms;
        logic scale_peak;
        logic scale_decay;
        logic commit;
        logic commit_block;
    } asl_cmd_t;

    typedef struct packed {
        logic col_end;
        logic blk_end;
        logic div_done;
        logic sqrt_done;
        logic peak_up;
        logic need_decay;
        logic out_free;
    } asl_status_t;

endpackage

>>> rtl/asl_divider.sv
// ----------------------------------------------------------------------------
// asl_divider
// Restoring divider, one quotient bit per cycle. Shared by the mean-square
// divide and the scale decay divide.
// ----------------------------------------------------------------------------
module asl_divider
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [asl_pkg::SUM_W-1:0] dividend,
    input  logic [asl_pkg::CNT_W-1:0] divisor,
    output logic [asl_pkg::SUM_W-1:0] quotient,
    output logic                      done
);

    localparam int STEP_W = $clog2(asl_pkg::SUM_W);

    logic [asl_pkg::SUM_W-1:0] shift_reg;
    logic [asl_pkg::CNT_W-1:0] rem_reg;
    logic [asl_pkg::CNT_W-1:0] dvs_reg;
    logic [STEP_W-1:0]         cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic [asl_pkg::CNT_W:0]   rem_try;
    logic [asl_pkg::CNT_W:0]   rem_sub;
    logic                      ge;

    always_comb
    begin
        rem_try = {rem_reg, shift_reg[asl_pkg::SUM_W-1]};
        ge      = rem_try >= {1'b0, dvs_reg};
        rem_sub = rem_try - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + STEP_W'(1);
                if (cnt_reg == STEP_W'(asl_pkg::SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
            dvs_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[asl_pkg::SUM_W-2:0], ge};
            rem_reg   <= ge ? rem_sub[asl_pkg::CNT_W-1:0] : rem_try[asl_pkg::CNT_W-1:0];
        end
    end

    assign quotient = shift_reg;
    assign done     = done_reg;

endmodule

>>> rtl/asl_isqrt.sv
// ----------------------------------------------------------------------------
// asl_isqrt
// Integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module asl_isqrt
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [asl_pkg::SUM_W-1:0]  radicand,
    output logic [asl_pkg::ROOT_W-1:0] root,
    output logic                       done
);

    localparam int STEP_W = $clog2(asl_pkg::ROOT_W);

    logic [asl_pkg::SUM_W-1:0] val_reg;
    logic [asl_pkg::SUM_W-1:0] res_reg;
    logic [asl_pkg::SUM_W-1:0] bit_reg;
    logic [STEP_W-1:0]         cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic [asl_pkg::SUM_W:0]   trial;
    logic                      ge;

    always_comb
    begin
        trial = {1'b0, res_reg} + {1'b0, bit_reg};
        ge    = {1'b0, val_reg} >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + STEP_W'(1);
                if (cnt_reg == STEP_W'(asl_pkg::ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // highest even power of two that fits the radicand
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg <= radicand;
            res_reg <= '0;
            bit_reg <= {2'b01, {(asl_pkg::SUM_W-2){1'b0}}};
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                val_reg <= val_reg - trial[asl_pkg::SUM_W-1:0];
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign root = res_reg[asl_pkg::ROOT_W-1:0];
    assign done = done_reg;

endmodule

>>> rtl/asl_datapath.sv
// ----------------------------------------------------------------------------
// asl_datapath
// Configuration registers, column/block/window accumulators, scale tracker
// and output register, driven by commands from the controller.
// ----------------------------------------------------------------------------
module asl_datapath
#(
    parameter int RING_COLUMNS = asl_pkg::DEF_RING_COLUMNS,
    parameter int SLOT_W       = (RING_COLUMNS > 1) ? $clog2(RING_COLUMNS) : 1
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [asl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [asl_pkg::CFG_W-1:0]           cfg_data,
    input  logic signed [asl_pkg::SAMPLE_W-1:0] sample,
    input  asl_pkg::asl_cmd_t                   cmd,
    output asl_pkg::asl_status_t                status,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic signed [asl_pkg::SAMPLE_W-1:0] column_min,
    output logic signed [asl_pkg::SAMPLE_W-1:0] column_max,
    output logic [SLOT_W-1:0]                   column_slot,
    output logic                                block_done,
    output logic [asl_pkg::LEVEL_W-1:0]         full_scale,
    output logic [asl_pkg::LEVEL_W-1:0]         rms_level,
    output logic [asl_pkg::LEVEL_W-1:0]         window_peak
);

    // configuration
    logic [7:0]  spc_reg;
    logic [6:0]  cpb_reg;
    logic [15:0] floor_reg;
    logic [7:0]  div_reg;
    logic [9:0]  bpw_reg;

    logic [7:0]  spc_eff;
    logic [6:0]  cpb_eff;
    logic [15:0] floor_eff;
    logic [7:0]  div_eff;
    logic [9:0]  bpw_eff;

    // sample stage
    logic signed [asl_pkg::SAMPLE_W-1:0] smp_reg;
    logic [asl_pkg::LEVEL_W-1:0]         abs_reg;
    logic [asl_pkg::SQ_W-1:0]            sq_reg;
    logic [asl_pkg::LEVEL_W-1:0]         in_abs;

    // accumulators
    logic signed [asl_pkg::SAMPLE_W-1:0] run_min_reg;
    logic signed [asl_pkg::SAMPLE_W-1:0] run_max_reg;
    logic [asl_pkg::LEVEL_W-1:0]         blk_peak_reg;
    logic [asl_pkg::LEVEL_W-1:0]         win_peak_reg;
    logic [asl_pkg::SUM_W-1:0]           sum_reg;
    logic [asl_pkg::CNT_W-1:0]           count_reg;

    logic [7:0]                          sic_reg;
    logic [5:0]                          cib_reg;
    logic [9:0]                          biw_reg;
    logic [SLOT_W-1:0]                   head_reg;
    logic [asl_pkg::LEVEL_W-1:0]         scale_reg;
    logic [asl_pkg::LEVEL_W-1:0]         last_rms_reg;

    logic [asl_pkg::LEVEL_W-1:0]         scale_clamped;
    logic                                win_end;
    logic                                head_wrap;

    // output register
    logic                                out_valid_reg;
    logic signed [asl_pkg::SAMPLE_W-1:0] o_min_reg;
    logic signed [asl_pkg::SAMPLE_W-1:0] o_max_reg;
    logic [SLOT_W-1:0]                   o_slot_reg;
    logic                                o_done_reg;
    logic [asl_pkg::LEVEL_W-1:0]         o_scale_reg;
    logic [asl_pkg::LEVEL_W-1:0]         o_rms_reg;
    logic [asl_pkg::LEVEL_W-1:0]         o_peak_reg;

    // divider and square-root units
    logic [asl_pkg::SUM_W-1:0]           div_dividend;
    logic [asl_pkg::CNT_W-1:0]           div_divisor;
    logic [asl_pkg::SUM_W-1:0]           div_quotient;
    logic                                div_done;
    logic [asl_pkg::ROOT_W-1:0]          sqrt_root;
    logic                                sqrt_done;

    always_comb
    begin
        spc_eff   = (spc_reg == 8'd0) ? 8'd1 : spc_reg;
        div_eff   = (div_reg == 8'd0) ? 8'd1 : div_reg;
        bpw_eff   = (bpw_reg == 10'd0) ? 10'd1 : bpw_reg;
        if (cpb_reg == 7'd0)
            cpb_eff = 7'd1;
        else if (cpb_reg > asl_pkg::MAX_CPB)
            cpb_eff = asl_pkg::MAX_CPB;
        else
            cpb_eff = cpb_reg;
        if (floor_reg == 16'd0)
            floor_eff = 16'd1;
        else if (floor_reg > asl_pkg::MAX_FLOOR)
            floor_eff = asl_pkg::MAX_FLOOR;
        else
            floor_eff = floor_reg;
    end

    // two's complement magnitude; -32768 maps to 32768
    assign in_abs = sample[asl_pkg::SAMPLE_W-1] ? (~sample + 16'd1) : sample;

    always_comb
    begin
        scale_clamped = (scale_reg < floor_eff) ? floor_eff : scale_reg;
        win_end       = ({1'b0, biw_reg} + 11'd1) >= {1'b0, bpw_eff};
        head_wrap     = ({1'b0, head_reg} + (SLOT_W+1)'(1)) >= (SLOT_W+1)'(RING_COLUMNS);
    end

    always_comb
    begin
        status.col_end    = ({1'b0, sic_reg} + 9'd1) >= {1'b0, spc_eff};
        status.blk_end    = ({1'b0, cib_reg} + 7'd1) >= cpb_eff;
        status.div_done   = div_done;
        status.sqrt_done  = sqrt_done;
        status.peak_up    = blk_peak_reg > scale_reg;
        status.need_decay = scale_reg > floor_eff;
        status.out_free   = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        if (cmd.div_decay)
        begin
            div_dividend = asl_pkg::SUM_W'(scale_reg - floor_eff);
            div_divisor  = asl_pkg::CNT_W'(div_eff);
        end
        else
        begin
            div_dividend = sum_reg;
            div_divisor  = count_reg;
        end
    end

    asl_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    asl_isqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (div_quotient),
        .root     (sqrt_root),
        .done     (sqrt_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spc_reg   <= asl_pkg::RST_SPC;
            cpb_reg   <= asl_pkg::RST_CPB;
            floor_reg <= asl_pkg::RST_FLOOR;
            div_reg   <= asl_pkg::RST_DIV;
            bpw_reg   <= asl_pkg::RST_BPW;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                asl_pkg::CFG_SPC:   spc_reg   <= cfg_data[7:0];
                asl_pkg::CFG_CPB:   cpb_reg   <= cfg_data[6:0];
                asl_pkg::CFG_FLOOR: floor_reg <= cfg_data;
                asl_pkg::CFG_DIV:   div_reg   <= cfg_data[7:0];
                asl_pkg::CFG_BPW:   bpw_reg   <= cfg_data[9:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            smp_reg <= sample;
            abs_reg <= in_abs;
            sq_reg  <= {16'd0, in_abs} * {16'd0, in_abs};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_min_reg   <= asl_pkg::MIN_INIT;
            run_max_reg   <= asl_pkg::MAX_INIT;
            blk_peak_reg  <= '0;
            win_peak_reg  <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            sic_reg       <= '0;
            cib_reg       <= '0;
            biw_reg       <= '0;
            head_reg      <= '0;
            scale_reg     <= asl_pkg::RST_FLOOR;
            last_rms_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accumulate)
            begin
                if (smp_reg < run_min_reg)
                    run_min_reg <= smp_reg;
                if (smp_reg > run_max_reg)
                    run_max_reg <= smp_reg;
                if (abs_reg > blk_peak_reg)
                    blk_peak_reg <= abs_reg;
                if (abs_reg > win_peak_reg)
                    win_peak_reg <= abs_reg;
                sum_reg   <= sum_reg + asl_pkg::SUM_W'(sq_reg);
                count_reg <= count_reg + asl_pkg::CNT_W'(1);
            end

            if (cmd.step_sample)
                sic_reg <= sic_reg + 8'd1;

            if (cmd.store_rms)
                last_rms_reg <= (count_reg == '0) ? '0 : sqrt_root[asl_pkg::LEVEL_W-1:0];

            if (cmd.scale_peak)
                scale_reg <= blk_peak_reg;
            else if (cmd.scale_decay)
                scale_reg <= scale_reg - div_quotient[asl_pkg::LEVEL_W-1:0];

            if (cmd.commit)
            begin
                run_min_reg <= asl_pkg::MIN_INIT;
                run_max_reg <= asl_pkg::MAX_INIT;
                sic_reg     <= '0;
                head_reg    <= head_wrap ? '0 : head_reg + SLOT_W'(1);
                if (cmd.commit_block)
                begin
                    cib_reg      <= '0;
                    blk_peak_reg <= '0;
                    scale_reg    <= scale_clamped;
                    if (win_end)
                    begin
                        biw_reg      <= '0;
                        sum_reg      <= '0;
                        count_reg    <= '0;
                        win_peak_reg <= '0;
                    end
                    else
                    begin
                        biw_reg <= biw_reg + 10'd1;
                    end
                end
                else
                begin
                    cib_reg <= cib_reg + 6'd1;
                end
            end

            if (cmd.commit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            o_min_reg   <= run_min_reg;
            o_max_reg   <= run_max_reg;
            o_slot_reg  <= head_reg;
            o_done_reg  <= cmd.commit_block;
            o_scale_reg <= cmd.commit_block ? scale_clamped : scale_reg;
            o_rms_reg   <= last_rms_reg;
            o_peak_reg  <= win_peak_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign column_min  = o_min_reg;
    assign column_max  = o_max_reg;
    assign column_slot = o_slot_reg;
    assign block_done  = o_done_reg;
    assign full_scale  = o_scale_reg;
    assign rms_level   = o_rms_reg;
    assign window_peak = o_peak_reg;

endmodule

>>> rtl/asl_ctrl.sv
// ----------------------------------------------------------------------------
// asl_ctrl
// Sequencer: takes a sample, folds it in, closes columns and runs the
// block-end divide, root and scale update.
// ----------------------------------------------------------------------------
module asl_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  asl_pkg::asl_status_t status,
    output asl_pkg::asl_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_ACC     = 3'd1;
    localparam logic [2:0] S_COL     = 3'd2;
    localparam logic [2:0] S_DIV_RMS = 3'd3;
    localparam logic [2:0] S_SQRT    = 3'd4;
    localparam logic [2:0] S_SCALE   = 3'd5;
    localparam logic [2:0] S_DIV_DEC = 3'd6;
    localparam logic [2:0] S_FIN     = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                cmd.accumulate = 1'b1;
                if (status.col_end)
                begin
                    state_next = S_COL;
                end
                else
                begin
                    cmd.step_sample = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_COL:
            begin
                if (status.blk_end)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV_RMS;
                end
                else if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DIV_RMS:
            begin
                if (status.div_done)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (status.sqrt_done)
                begin
                    cmd.store_rms = 1'b1;
                    state_next    = S_SCALE;
                end
            end
            S_SCALE:
            begin
                if (status.peak_up)
                begin
                    cmd.scale_peak = 1'b1;
                    state_next     = S_FIN;
                end
                else if (status.need_decay)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_decay = 1'b1;
                    state_next    = S_DIV_DEC;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DIV_DEC:
            begin
                if (status.div_done)
                begin
                    cmd.scale_decay = 1'b1;
                    state_next      = S_FIN;
                end
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.commit       = 1'b1;
                    cmd.commit_block = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

>>> rtl/audio_scope_level_tracker.sv
// ----------------------------------------------------------------------------
// audio_scope_level_tracker
// Column min/max decimator with peak-following display scale, window RMS
// and window peak.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/sample carries one audio sample per
//   request. Output channel out_valid/out_stall carries one column result
//   when a column closes; samples inside a column give no result.
//   Configuration is a write-only port (cfg_write, cfg_index, cfg_data);
//   write it only while the block is idle.
//   A sample that does not close a column passes the IDLE and ACC states;
//   a column close passes COL as well. A block close runs the shared
//   bit-serial divider on sum/count, then the 2-bits-per-cycle root,
//   and, on decay, the divider again. No new sample is taken until the
//   controller is back in IDLE.
//   While out_stall is high a finished result is held in the output
//   register; the next sample is still taken, and the block waits only
//   when it has another result to place there.
//   Reset clears all counters and accumulators, restores the register
//   defaults and sets the scale to the default floor; no result is pending.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module audio_scope_level_tracker
#(
    parameter int RING_COLUMNS = asl_pkg::DEF_RING_COLUMNS,
    parameter int SLOT_W       = (RING_COLUMNS > 1) ? $clog2(RING_COLUMNS) : 1
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [asl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [asl_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [asl_pkg::SAMPLE_W-1:0] sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [asl_pkg::SAMPLE_W-1:0] column_min,
    output logic signed [asl_pkg::SAMPLE_W-1:0] column_max,
    output logic [SLOT_W-1:0]                   column_slot,
    output logic                                block_done,
    output logic [asl_pkg::LEVEL_W-1:0]         full_scale,
    output logic [asl_pkg::LEVEL_W-1:0]         rms_level,
    output logic [asl_pkg::LEVEL_W-1:0]         window_peak
);

    asl_pkg::asl_cmd_t    cmd;
    asl_pkg::asl_status_t status;

    asl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    asl_datapath
    #(
        .RING_COLUMNS (RING_COLUMNS),
        .SLOT_W       (SLOT_W)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sample      (sample),
        .cmd         (cmd),
        .status      (status),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .column_min  (column_min),
        .column_max  (column_max),
        .column_slot (column_slot),
        .block_done  (block_done),
        .full_scale  (full_scale),
        .rms_level   (rms_level),
        .window_peak (window_peak)
    );

    // an accepted sample always raises in_stall in the cycle after it is taken
    `ASL_ASSERT(a_accept_then_busy, (in_valid && !in_stall) |=> in_stall, "sample taken twice")
    `ASL_ASSERT_OUT(a_scale_nonzero, full_scale != '0, "scale below floor")
    `ASL_ASSERT_OUT(a_slot_range, int'(column_slot) < RING_COLUMNS, "slot out of ring")
    `ASL_ASSERT_OUT(a_min_le_max, column_min <= column_max, "column min above max")

endmodule

>>> verif/tb_audio_scope_level_tracker.sv
// ----------------------------------------------------------------------------
// tb_audio_scope_level_tracker
// Self-checking bench for the audio scope level tracker. A queue-fed driver
// sends samples with random gaps, a monitor takes column results with random
// stalls, and an in-bench tracker model predicts min/max, slot, scale, RMS
// and peak for every column. Register settings change between drained phases.
// ----------------------------------------------------------------------------
module tb_audio_scope_level_tracker;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_BITS     = $clog2(asl_pkg::DEF_RING_COLUMNS);
    localparam int SETTLE_CYCLES = 200;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef struct {
        logic signed [asl_pkg::SAMPLE_W-1:0] lo;
        logic signed [asl_pkg::SAMPLE_W-1:0] hi;
        logic [SLOT_BITS-1:0]                slot;
        logic                                done;
        logic [asl_pkg::LEVEL_W-1:0]         scale;
        logic [asl_pkg::LEVEL_W-1:0]         rms;
        logic [asl_pkg::LEVEL_W-1:0]         peak;
    } column_rec_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_write = 1'b0;
    logic [asl_pkg::CFG_IDX_W-1:0]       cfg_index = asl_pkg::CFG_SPC;
    logic [asl_pkg::CFG_W-1:0]           cfg_data = '0;
    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic signed [asl_pkg::SAMPLE_W-1:0] sample = '0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic signed [asl_pkg::SAMPLE_W-1:0] column_min;
    logic signed [asl_pkg::SAMPLE_W-1:0] column_max;
    logic [SLOT_BITS-1:0]                column_slot;
    logic                                block_done;
    logic [asl_pkg::LEVEL_W-1:0]         full_scale;
    logic [asl_pkg::LEVEL_W-1:0]         rms_level;
    logic [asl_pkg::LEVEL_W-1:0]         window_peak;

    // register shadow
    logic [7:0]  set_spc;
    logic [6:0]  set_cpb;
    logic [15:0] set_floor;
    logic [7:0]  set_div;
    logic [9:0]  set_bpw;

    // tracker model state
    logic signed [asl_pkg::SAMPLE_W-1:0] col_lo, col_hi;
    logic [7:0]                          samples_in_col;
    logic [5:0]                          cols_in_block;
    logic [SLOT_BITS-1:0]                ring_pos;
    logic [asl_pkg::LEVEL_W-1:0]         blk_mag_max, win_peak;
    logic [asl_pkg::SUM_W-1:0]           energy_sum;
    logic [asl_pkg::CNT_W-1:0]           energy_count;
    logic [9:0]                          blocks_in_window;
    logic [asl_pkg::LEVEL_W-1:0]         scale_now, rms_now;

    logic signed [asl_pkg::SAMPLE_W-1:0] sample_backlog[$];
    column_rec_t                         pending_columns[$];

    int  mismatches = 0;
    int  samples_sent = 0;
    int  columns_seen = 0;
    int  blocks_seen = 0;
    int  settings_used = 0;
    int  cycle_count = 0;
    int  tx_gap = 0;
    int  rx_hold = 0;
    bit  tx_quiet = 1'b0;
    bit  rx_quiet = 1'b0;

    audio_scope_level_tracker dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .column_min  (column_min),
        .column_max  (column_max),
        .column_slot (column_slot),
        .block_done  (block_done),
        .full_scale  (full_scale),
        .rms_level   (rms_level),
        .window_peak (window_peak)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [asl_pkg::LEVEL_W-1:0] floor_root(
        logic [asl_pkg::SUM_W-1:0] v);
        logic [31:0] r;
        logic [31:0] t;
        int          b;
        r = '0;
        for (b = asl_pkg::ROOT_W - 1; b >= 0; b--)
        begin
            t = r | (32'd1 << b);
            if (64'(t) * 64'(t) <= 64'(v))
                r = t;
        end
        return asl_pkg::LEVEL_W'(r);
    endfunction

    // Folds one accepted sample into the model; queues a column when one closes.
    function automatic void track_sample(logic signed [asl_pkg::SAMPLE_W-1:0] s);
        logic [asl_pkg::LEVEL_W-1:0] mag;
        logic [asl_pkg::LEVEL_W-1:0] flo;
        logic [7:0]                  spc_v;
        logic [6:0]                  cpb_v;
        logic [7:0]                  div_v;
        logic [9:0]                  bpw_v;
        logic [asl_pkg::SUM_W-1:0]   mean;
        column_rec_t                 rec;
        mag   = s[asl_pkg::SAMPLE_W-1] ? asl_pkg::LEVEL_W'(-s) : asl_pkg::LEVEL_W'(s);
        spc_v = (set_spc == 0) ? 8'd1 : set_spc;
        cpb_v = (set_cpb == 0) ? 7'd1 :
                ((set_cpb > asl_pkg::MAX_CPB) ? asl_pkg::MAX_CPB : set_cpb);
        div_v = (set_div == 0) ? 8'd1 : set_div;
        bpw_v = (set_bpw == 0) ? 10'd1 : set_bpw;
        flo   = (set_floor == 0) ? 16'd1 :
                ((set_floor > asl_pkg::MAX_FLOOR) ? asl_pkg::MAX_FLOOR : set_floor);

        if (s < col_lo)
            col_lo = s;
        if (s > col_hi)
            col_hi = s;
        if (mag > blk_mag_max)
            blk_mag_max = mag;
        if (mag > win_peak)
            win_peak = mag;
        energy_sum   = energy_sum + asl_pkg::SUM_W'(mag) * asl_pkg::SUM_W'(mag);
        energy_count = energy_count + 1'b1;

        // a counter at or past a lowered limit closes on this count
        if (samples_in_col + 1 < spc_v)
        begin
            samples_in_col++;
            return;
        end
        samples_in_col = '0;
        rec.lo   = col_lo;
        rec.hi   = col_hi;
        col_lo   = asl_pkg::MIN_INIT;
        col_hi   = asl_pkg::MAX_INIT;
        rec.slot = ring_pos;
        ring_pos = (ring_pos + 1 >= asl_pkg::DEF_RING_COLUMNS) ? '0 : ring_pos + 1'b1;
        rec.peak = win_peak;
        rec.done = 1'b0;

        if (cols_in_block + 1 < cpb_v)
            cols_in_block++;
        else
        begin
            cols_in_block = '0;
            rec.done = 1'b1;
            mean    = energy_sum / asl_pkg::SUM_W'(energy_count);
            rms_now = floor_root(mean);
            if (blk_mag_max > scale_now)
                scale_now = blk_mag_max;
            else if (scale_now > flo)
                scale_now = scale_now - (scale_now - flo) / div_v;
            if (scale_now < flo)
                scale_now = flo;
            blk_mag_max = '0;
            if (blocks_in_window + 1 < bpw_v)
                blocks_in_window++;
            else
            begin
                blocks_in_window = '0;
                energy_sum       = '0;
                energy_count     = '0;
                win_peak         = '0;
            end
        end
        rec.scale = scale_now;
        rec.rms   = rms_now;
        pending_columns.push_back(rec);
    endfunction

    function automatic void compare_field(string label, int want, int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
        end
    endfunction

    // sample driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                track_sample(sample);
                samples_sent++;
                tx_gap = tx_quiet ? 0 : $urandom_range(0, 7);
                if ($urandom_range(0, 49) == 0)
                    tx_quiet = !tx_quiet;
            end
            if (in_valid && in_stall)
            begin
                // request still waiting, payload held
            end
            else if (tx_gap != 0)
            begin
                tx_gap--;
                in_valid <= 1'b0;
            end
            else if (sample_backlog.size() != 0)
            begin
                sample   <= sample_backlog.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // column monitor
    always @(posedge clk)
    begin
        column_rec_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                columns_seen++;
                if (pending_columns.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected column, expected none, got min %0d max %0d slot %0d",
                             $time, column_min, column_max, column_slot);
                end
                else
                begin
                    want = pending_columns.pop_front();
                    if (want.done)
                        blocks_seen++;
                    compare_field("column_min", int'(want.lo), int'(column_min));
                    compare_field("column_max", int'(want.hi), int'(column_max));
                    compare_field("column_slot", int'(want.slot), int'(column_slot));
                    compare_field("block_done", int'(want.done), int'(block_done));
                    compare_field("full_scale", int'(want.scale), int'(full_scale));
                    compare_field("rms_level", int'(want.rms), int'(rms_level));
                    compare_field("window_peak", int'(want.peak), int'(window_peak));
                end
                rx_hold = rx_quiet ? 0 : $urandom_range(0, 7);
                if ($urandom_range(0, 49) == 0)
                    rx_quiet = !rx_quiet;
            end
            else if (rx_hold != 0)
                rx_hold--;
            out_stall <= (rx_hold != 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d columns still outstanding", $time,
                     pending_columns.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // wait for every sample taken and every column back, then idle a while
    task automatic settle();
        while (sample_backlog.size() != 0 || in_valid || pending_columns.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [asl_pkg::CFG_IDX_W-1:0] idx,
                             logic [asl_pkg::CFG_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            asl_pkg::CFG_SPC:   set_spc   = data[7:0];
            asl_pkg::CFG_CPB:   set_cpb   = data[6:0];
            asl_pkg::CFG_FLOOR: set_floor = data[15:0];
            asl_pkg::CFG_DIV:   set_div   = data[7:0];
            asl_pkg::CFG_BPW:   set_bpw   = data[9:0];
            default:            ;
        endcase
    endtask

    task automatic load_settings(logic [15:0] spc, logic [15:0] cpb, logic [15:0] flo,
                                 logic [15:0] div, logic [15:0] bpw);
        settle();
        write_reg(asl_pkg::CFG_SPC, spc);
        write_reg(asl_pkg::CFG_CPB, cpb);
        write_reg(asl_pkg::CFG_FLOOR, flo);
        write_reg(asl_pkg::CFG_DIV, div);
        write_reg(asl_pkg::CFG_BPW, bpw);
        settings_used++;
    endtask

    // audio-like samples: loudness changes in bursts so the scale both jumps and decays
    task automatic queue_audio(int n);
        int k;
        int amp;
        logic signed [asl_pkg::SAMPLE_W-1:0] v;
        amp = 0;
        for (k = 0; k < n; k++)
        begin
            if (k % 24 == 0)
                case ($urandom_range(0, 2))
                    0:       amp = $urandom_range(0, 300);
                    1:       amp = $urandom_range(300, 6000);
                    default: amp = 32767;
                endcase
            case ($urandom_range(0, 15))
                0:       v = 16'sh8000;
                1:       v = 16'sh7FFF;
                2, 3:    v = asl_pkg::SAMPLE_W'($urandom());
                default: v = asl_pkg::SAMPLE_W'(int'($urandom_range(0, 2 * amp)) - amp);
            endcase
            sample_backlog.push_back(v);
        end
    endtask

    initial
    begin
        logic signed [asl_pkg::SAMPLE_W-1:0] dir_a[10];
        logic signed [asl_pkg::SAMPLE_W-1:0] dir_b[9];
        logic [15:0] spc_w, cpb_w, flo_w, div_w, bpw_w;
        int ph;

        dir_a = '{16'sh8000, 16'sh7FFF, 16'sh0000, -16'sd1, 16'sd1,
                  16'sh4000, -16'sd16384, 16'sh7FFF, 16'sh8000, 16'sh0000};
        dir_b = '{16'sd5, -16'sd5, 16'sd0, 16'sh7FFF, 16'sd100, -16'sd200,
                  16'sd0, 16'sd0, 16'sd0};

        set_spc          = asl_pkg::RST_SPC;
        set_cpb          = asl_pkg::RST_CPB;
        set_floor        = asl_pkg::RST_FLOOR;
        set_div          = asl_pkg::RST_DIV;
        set_bpw          = asl_pkg::RST_BPW;
        col_lo           = asl_pkg::MIN_INIT;
        col_hi           = asl_pkg::MAX_INIT;
        samples_in_col   = '0;
        cols_in_block    = '0;
        ring_pos         = '0;
        blk_mag_max      = '0;
        win_peak         = '0;
        energy_sum       = '0;
        energy_count     = '0;
        blocks_in_window = '0;
        scale_now        = asl_pkg::RST_FLOOR;
        rms_now          = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // power-on register values
        queue_audio(100);

        // full-scale extremes; zero floor and zero divisor act as one
        load_settings(16'd1, 16'd3, 16'd0, 16'd0, 16'd2);
        foreach (dir_a[i])
            sample_backlog.push_back(dir_a[i]);

        // floor above range clamps to full scale, scale pulled up to it
        load_settings(16'd3, 16'd0, 16'hFFFF, 16'd255, 16'd0);
        foreach (dir_b[i])
            sample_backlog.push_back(dir_b[i]);

        // column length cut below the current count; oversized block length
        load_settings(16'd7, 16'd2, 16'd1, 16'd1, 16'd1);
        for (ph = 1; ph <= 5; ph++)
            sample_backlog.push_back(asl_pkg::SAMPLE_W'(ph));
        load_settings(16'd2, 16'd100, 16'd1, 16'd1, 16'd1);
        sample_backlog.push_back(-16'sd7);
        sample_backlog.push_back(16'sd7);
        sample_backlog.push_back(16'sd0);

        // longest columns, largest floor and window
        load_settings(16'd255, 16'd1, 16'd32768, 16'd1, 16'd1023);
        queue_audio(260);

        // one sample per column, longest blocks, slowest decay
        load_settings(16'd1, 16'd64, 16'd1, 16'd255, 16'd1);
        queue_audio(200);

        for (ph = 0; ph < 10; ph++)
        begin
            spc_w = 16'($urandom_range(0, 6));
            case ($urandom_range(0, 5))
                0:       cpb_w = 16'd64;
                1:       cpb_w = 16'd127;
                default: cpb_w = 16'($urandom_range(0, 6));
            endcase
            case ($urandom_range(0, 3))
                0:       flo_w = 16'($urandom());
                1:       flo_w = 16'd32768;
                default: flo_w = 16'($urandom_range(0, 4000));
            endcase
            div_w = ($urandom_range(0, 4) == 0) ? 16'd255 : 16'($urandom_range(0, 40));
            bpw_w = ($urandom_range(0, 4) == 0) ? 16'd1023 : 16'($urandom_range(0, 6));
            load_settings(spc_w, cpb_w, flo_w, div_w, bpw_w);
            queue_audio(100);
        end

        settle();
        $display("Sent %0d samples under %0d register settings plus power-on values;",
                 samples_sent, settings_used);
        $display("checked %0d columns, %0d of them closing a block.",
                 columns_seen, blocks_seen);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
